// ===== rtl/positional_insert_delete_list_top_macros.svh =====
// assertion macros for the positional insert/delete list
// used by the top level; expects clk and rst_n in the including scope
`ifndef POSITIONAL_INSERT_DELETE_LIST_TOP_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PIDL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidl assertion failed");

// next-cycle implication, disabled during reset
`define PIDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidl assertion failed");

`endif

// ===== rtl/pidl_pkg.sv =====
// shared types and constants for the positional insert/delete list
// no dependencies
package pidl_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 6;
  // wide enough to compare a position against a count of up to 64
  localparam int CMP_W  = POS_W + 1;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                  op;
    logic [CMP_W-1:0]          pos;
    logic [CMP_W-1:0]          last_idx;
    logic signed [WORD_W-1:0]  value;
  } cell_ctrl_t;

endpackage

// ===== rtl/pidl_if.sv =====
// valid/ready channel interfaces for the command input and the result output
// depends on pidl_pkg
interface pidl_in_if import pidl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [POS_W-1:0]          position;
  logic signed [WORD_W-1:0]  value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface pidl_out_if import pidl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  read_value;
  logic [POS_W-1:0]          read_index;
  logic                      last;
  logic [1:0]                status;

  modport source (output valid, output read_value, output read_index, output last,
                  output status, input ready);
  modport sink   (input valid, input read_value, input read_index, input last,
                  input status, output ready);
endinterface

// ===== rtl/pidl_cell.sv =====
// one storage cell of the list chain: holds a word and shifts with its neighbors
// depends on pidl_pkg
module pidl_cell import pidl_pkg::*; (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic [CMP_W-1:0]          idx,
  input  logic signed [WORD_W-1:0]  lower,
  input  logic signed [WORD_W-1:0]  upper,
  input  logic signed [WORD_W-1:0]  wrap,
  output logic signed [WORD_W-1:0]  q
);

  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (ctrl.op)
      CELL_INS: begin
        if (idx > ctrl.pos) begin
          word_nxt = lower;
        end else if (idx == ctrl.pos) begin
          word_nxt = ctrl.value;
        end
      end
      CELL_DEL: begin
        if (idx >= ctrl.pos) begin
          word_nxt = upper;
        end
      end
      CELL_ROT: begin
        // rotate only the used part of the list, head wraps to the tail
        if (idx < ctrl.last_idx) begin
          word_nxt = upper;
        end else if (idx == ctrl.last_idx) begin
          word_nxt = wrap;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

// ===== rtl/positional_insert_delete_list_top.sv =====
// top level of the positional insert/delete list: controller, cell chain, output register
// depends on pidl_pkg, pidl_if, pidl_cell and the assertion macro header
//
//  channel  | dir | payload                                  | transfer when
//  ---------+-----+------------------------------------------+----------------
//  in_ch    | in  | cmd, position, value                     | valid && ready
//  out_ch   | out | read_value, read_index, last, status     | valid && ready
//
// a valid insert or delete shifts the cells from the position up at once; the status
// result appears in the output register on the next cycle.
// display of a non-empty list enters the stream state, then one result per cycle while not
// stalled, as the chain rotates by one position; the chain is back in order afterwards.
// no new command is taken while a display streams or a result waits in the output register.
// a stalled output holds its result and the rotation waits with it.
// reset clears the count, the stream state and the output valid; the words are not cleared.
`include "positional_insert_delete_list_top_macros.svh"

module positional_insert_delete_list_top import pidl_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  pidl_in_if.sink      in_ch,
  pidl_out_if.source   out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [CNT_W-1:0]          disp_r;
  logic [CNT_W-1:0]          disp_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic signed [WORD_W-1:0]  out_value_r;
  logic signed [WORD_W-1:0]  out_value_nxt;
  logic [POS_W-1:0]          out_index_r;
  logic [POS_W-1:0]          out_index_nxt;
  logic                      out_last_r;
  logic                      out_last_nxt;
  logic [1:0]                out_status_r;
  logic [1:0]                out_status_nxt;

  logic                      out_free;
  logic                      accept;
  logic [CMP_W-1:0]          pos_x;
  logic [CMP_W-1:0]          cnt_x;
  logic                      full;
  logic                      ins_ok;
  logic                      del_ok;
  logic                      stream_last;
  cell_ctrl_t                ctrl;
  logic signed [WORD_W-1:0]  cell_q [DEPTH];

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  assign pos_x       = {1'b0, in_ch.position};
  assign cnt_x       = CMP_W'(count_r);
  assign full        = (count_r == CNT_W'(DEPTH));
  assign ins_ok      = !full && (pos_x <= cnt_x);
  assign del_ok      = (pos_x < cnt_x);
  assign stream_last = (disp_r == count_r - CNT_W'(1));

  // cell chain control
  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.pos      = pos_x;
    ctrl.last_idx = cnt_x - CMP_W'(1);
    ctrl.value    = in_ch.value;
    if (accept) begin
      case (in_ch.cmd)
        CMD_INSERT: if (ins_ok) ctrl.op = CELL_INS;
        CMD_DELETE: if (del_ok) ctrl.op = CELL_DEL;
        default:    ctrl.op = CELL_HOLD;
      endcase
    end else if (state_r == S_STREAM && out_free) begin
      ctrl.op = CELL_ROT;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] lower_w;
    logic signed [WORD_W-1:0] upper_w;

    if (i == 0) begin : g_head
      assign lower_w = '0;
    end else begin : g_body
      assign lower_w = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign upper_w = cell_q[i];
    end else begin : g_next
      assign upper_w = cell_q[i+1];
    end

    pidl_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .idx   (CMP_W'(i)),
      .lower (lower_w),
      .upper (upper_w),
      .wrap  (cell_q[0]),
      .q     (cell_q[i])
    );
  end

  // controller and output register
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    disp_nxt       = disp_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_value_nxt = '0;
          out_index_nxt = '0;
          out_last_nxt  = 1'b1;
          case (in_ch.cmd)
            CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else if (!ins_ok) begin
                out_status_nxt = ST_BADPOS;
              end else begin
                out_status_nxt = ST_OK;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              out_valid_nxt = 1'b1;
              if (del_ok) begin
                out_status_nxt = ST_OK;
                count_nxt      = count_r - CNT_W'(1);
              end else begin
                out_status_nxt = ST_BADPOS;
              end
            end
            CMD_DISPLAY: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_STREAM;
                disp_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_STREAM: begin
        if (out_free) begin
          // head of the chain is the next entry in order
          out_valid_nxt  = 1'b1;
          out_value_nxt  = cell_q[0];
          out_index_nxt  = POS_W'(disp_r);
          out_last_nxt   = stream_last;
          out_status_nxt = ST_OK;
          disp_nxt       = disp_r + CNT_W'(1);
          if (stream_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      disp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      disp_r      <= disp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.read_index = out_index_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.status     = out_status_r;

  `PIDL_ASSERT_NEXT(a_ins_grows, accept && in_ch.cmd == CMD_INSERT && ins_ok, count_r == $past(count_r) + CNT_W'(1))
  `PIDL_ASSERT_NEXT(a_del_shrinks, accept && in_ch.cmd == CMD_DELETE && del_ok, count_r == $past(count_r) - CNT_W'(1))
  `PIDL_ASSERT_NOW(a_stream_nonempty, state_r == S_STREAM, count_r != '0 && disp_r < count_r)
  `PIDL_ASSERT_NEXT(a_stream_count_hold, state_r == S_STREAM, count_r == $past(count_r))

endmodule
